// ===== sv/u8rr_pkg.sv =====
// ----------------------------------------------------------------------------
// u8rr_pkg: shared types and constants of the utf-8 decoder with rtl reorder
// Field widths, code point constants, the right-to-left range table,
// sequencer states and the per-byte plan that the decoder hands on.
// ----------------------------------------------------------------------------
`default_nettype none

package u8rr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // replacement character and highest valid code point
  localparam cp_t CP_REPL = 21'd65533;
  localparam cp_t CP_MAX  = 21'd1114111;

  // lead byte class limits
  localparam byte_t ASCII_MAX = 8'h7F;
  localparam byte_t LEAD2_MAX = 8'd223;
  localparam byte_t LEAD3_MAX = 8'd239;
  localparam byte_t LEAD4_MAX = 8'd247;

  // continuation byte: top two bits are 10
  localparam logic [1:0] CONT_TAG = 2'b10;

  // right-to-left ranges, inclusive
  localparam int unsigned RTL_N = 36;

  localparam cp_t RTL_LO [RTL_N] = '{
    21'h005BE, 21'h005C0, 21'h005C3, 21'h005C6, 21'h005D0, 21'h00608,
    21'h0060B, 21'h0060D, 21'h0061B, 21'h0066D, 21'h00671, 21'h006E5,
    21'h006EE, 21'h006FA, 21'h00712, 21'h0074D, 21'h007B1, 21'h007F4,
    21'h007FA, 21'h0081A, 21'h00824, 21'h00828, 21'h00830, 21'h0085E,
    21'h0200F, 21'h0FB1D, 21'h0FB1F, 21'h0FB2A, 21'h0FD50, 21'h0FE70,
    21'h10800, 21'h10920, 21'h10A10, 21'h10A40, 21'h10B40, 21'h1EE00
  };

  localparam cp_t RTL_HI [RTL_N] = '{
    21'h005BE, 21'h005C0, 21'h005C3, 21'h005C6, 21'h005F4, 21'h00608,
    21'h0060B, 21'h0060D, 21'h0064A, 21'h0066F, 21'h006D5, 21'h006E6,
    21'h006EF, 21'h00710, 21'h0072F, 21'h007A5, 21'h007EA, 21'h007F5,
    21'h00815, 21'h0081A, 21'h00824, 21'h00828, 21'h00858, 21'h008AC,
    21'h0200F, 21'h0FB1D, 21'h0FB28, 21'h0FD3D, 21'h0FDFC, 21'h0FEFC,
    21'h1091B, 21'h10A00, 21'h10A33, 21'h10B35, 21'h10C48, 21'h1EEBB
  };

  // sequencer states of the run controller
  typedef enum logic [2:0] {
    S_IDLE,
    S_REP_FL,
    S_REP_EM,
    S_PT_FL,
    S_PT_ACT,
    S_END_FL
  } state_e;

  // what one input byte asks of the run controller
  typedef struct packed {
    logic rep;      // replacement for a broken sequence goes first
    logic pt_v;     // a decoded point follows
    cp_t  pt;
    logic str_end;  // string ends with this byte
  } plan_t;

  // code point lies in one of the right-to-left ranges
  function automatic logic is_rtl(cp_t c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < RTL_N; k++) begin
      if (c >= RTL_LO[k] && c <= RTL_HI[k]) hit = 1'b1;
    end
    return hit;
  endfunction

  // ascii whitespace or punctuation
  function automatic logic is_punct(cp_t c);
    return c inside {[21'h09:21'h0D], [21'h20:21'h2F], [21'h3A:21'h40],
                     [21'h5B:21'h60], [21'h7B:21'h7E]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/u8rr_if.sv =====
// ----------------------------------------------------------------------------
// u8rr_if: request channels of the utf-8 decoder
// Byte channel into the block and code point channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8rr_in_if import u8rr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  string_end;

  modport source (output valid, data_byte, string_end, input ready);
  modport sink   (input valid, data_byte, string_end, output ready);
endinterface

interface u8rr_out_if import u8rr_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  code_point;
  logic last_of_burst;

  modport source (output valid, code_point, last_of_burst, input ready);
  modport sink   (input valid, code_point, last_of_burst, output ready);
endinterface

`default_nettype wire

// ===== sv/utf8_decode_rtl_reorder_core.sv =====
// A point that is not right-to-left and needs no drain, replacement or string end is on
// the output the cycle after its byte is taken. Throughput: one byte per cycle unless the
// output stalls, a run drains, a sequence breaks or a string ends; then the byte waits
// while the buffered points drain newest first and its replacement and point are placed.
// Reset: decoder state, fill count and output valid clear at once; the run memory is not
// cleared, only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
// utf8_decode_rtl_reorder_core: utf-8 decoder with right-to-left run reorder
// Decodes one byte per request and emits code points in display order.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_rtl_reorder_core import u8rr_pkg::*; #(
  parameter int unsigned RUN_DEPTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u8rr_in_if.sink     in_i,
  u8rr_out_if.source  out_o
);

  plan_t plan;
  logic  in_ready;
  logic  accept;

  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  u8rr_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (in_i.data_byte),
    .string_end_i (in_i.string_end),
    .plan_o       (plan)
  );

  u8rr_run_ctrl #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_run_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_ready),
    .plan_i          (plan),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .code_point_o    (out_o.code_point),
    .last_of_burst_o (out_o.last_of_burst)
  );

endmodule

`default_nettype wire

// ===== sv/u8rr_ram.sv =====
// ----------------------------------------------------------------------------
// u8rr_ram: generic single-write, single-read memory
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module u8rr_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/u8rr_decode.sv =====
// ----------------------------------------------------------------------------
// u8rr_decode: lenient utf-8 byte decoder
// Tracks the pending multi-byte sequence and turns each byte into a plan:
// an optional replacement for a broken sequence and an optional code point.
// ----------------------------------------------------------------------------
`default_nettype none

module u8rr_decode import u8rr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  wire byte_t data_byte_i,
  input  wire logic  string_end_i,
  output plan_t      plan_o
);

  byte_t      lead_q, lead_d;
  logic [1:0] cont_q, cont_d;
  cp_t        part_q, part_d;
  logic       skip_q, skip_d;

  logic       is_cont;
  logic       do_start;
  logic [1:0] need;
  logic [1:0] cont_inc;
  cp_t        part_shift;

  assign is_cont    = (data_byte_i[7:6] == CONT_TAG);
  assign need       = (lead_q <= LEAD2_MAX) ? 2'd1 : (lead_q <= LEAD3_MAX) ? 2'd2 : 2'd3;
  assign cont_inc   = cont_q + 2'd1;
  assign part_shift = {part_q[CP_W-7:0], data_byte_i[5:0]};

  // decode step
  always_comb begin
    lead_d         = lead_q;
    cont_d         = cont_q;
    part_d         = part_q;
    skip_d         = skip_q;
    do_start       = 1'b0;
    plan_o.rep     = 1'b0;
    plan_o.pt_v    = 1'b0;
    plan_o.pt      = CP_REPL;
    plan_o.str_end = string_end_i;

    if (skip_q && is_cont) begin
      // continuation after a bad lead byte is dropped
      skip_d = skip_q;
    end else if (lead_q != '0) begin
      if (is_cont) begin
        if (cont_inc >= need) begin
          plan_o.pt_v = 1'b1;
          plan_o.pt   = (part_shift > CP_MAX) ? CP_REPL : part_shift;
          lead_d      = '0;
          cont_d      = '0;
          part_d      = '0;
        end else if (string_end_i) begin
          plan_o.pt_v = 1'b1;
        end else begin
          cont_d = cont_inc;
          part_d = part_shift;
        end
      end else begin
        // broken sequence: replacement, then this byte starts afresh
        lead_d     = '0;
        cont_d     = '0;
        part_d     = '0;
        plan_o.rep = 1'b1;
        do_start   = 1'b1;
      end
    end else begin
      skip_d   = 1'b0;
      do_start = 1'b1;
    end

    // byte opens a new point
    if (do_start) begin
      if (data_byte_i <= ASCII_MAX) begin
        plan_o.pt_v = 1'b1;
        plan_o.pt   = {{(CP_W-BYTE_W){1'b0}}, data_byte_i};
      end else if (data_byte_i <= LEAD4_MAX) begin
        if (string_end_i) begin
          plan_o.pt_v = 1'b1;
        end else begin
          lead_d = data_byte_i;
          cont_d = '0;
          part_d = (data_byte_i <= LEAD2_MAX) ? {{(CP_W-5){1'b0}}, data_byte_i[4:0]}
                                              : {{(CP_W-4){1'b0}}, data_byte_i[3:0]};
        end
      end else begin
        plan_o.pt_v = 1'b1;
        skip_d      = !string_end_i;
      end
    end

    // end of string clears the sequence state
    if (string_end_i) begin
      lead_d = '0;
      cont_d = '0;
      part_d = '0;
      skip_d = 1'b0;
    end
  end

  // sequence state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      cont_q <= '0;
      part_q <= '0;
      skip_q <= 1'b0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      cont_q <= cont_d;
      part_q <= part_d;
      skip_q <= skip_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/u8rr_run_ctrl.sv =====
// ----------------------------------------------------------------------------
// u8rr_run_ctrl: right-to-left run buffer and output sequencer
// Keeps the current run in a memory, writes rtl points at the fill count and
// drains the run in reverse through a one-deep read pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module u8rr_run_ctrl import u8rr_pkg::*; #(
  parameter int unsigned RUN_DEPTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire plan_t plan_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output cp_t        code_point_o,
  output logic       last_of_burst_o
);

  localparam int unsigned CW = $clog2(RUN_DEPTH + 1);
  localparam int unsigned AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(RUN_DEPTH);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          pend_q, pend_d;
  plan_t         plan_q;
  logic          rtl_q;
  logic          ov_q, ov_d;
  cp_t           ocp_q;
  logic          olast_q;

  logic          accept;
  logic          out_can;
  logic          in_rtl;
  logic          simple;
  logic          fast_wr;
  logic          fast_em;
  logic          fast;
  logic          flush_act;
  logic          push_fl;
  logic          issue;
  logic          fl_done;
  logic [CW-1:0] cnt_m1;

  logic          ram_we;
  cp_t           ram_wdata;
  logic          ram_re;
  cp_t           ram_rdata;
  logic          load;
  cp_t           ld_cp;
  logic          ld_last;

  // handshake and classification of the incoming point
  assign out_can    = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_can;
  assign accept     = in_valid_i && in_ready_o;
  assign in_rtl     = is_rtl(plan_i.pt) ||
                      (!plan_i.rep && (count_q != '0) && is_punct(plan_i.pt));
  assign simple     = !plan_i.rep && !plan_i.str_end;
  assign fast_wr    = simple && plan_i.pt_v && in_rtl && (count_q != FULL);
  assign fast_em    = simple && plan_i.pt_v && !in_rtl && (count_q == '0);
  assign fast       = simple && (!plan_i.pt_v || fast_wr || fast_em);

  // reverse drain: one read in flight, pushed when the output has room
  assign flush_act = (state_q inside {S_REP_FL, S_PT_FL, S_END_FL});
  assign push_fl   = pend_q && out_can;
  assign issue     = flush_act && (count_q != '0) && (!pend_q || push_fl);
  assign fl_done   = flush_act && (count_q == '0) && (!pend_q || push_fl);
  assign pend_d    = issue || (pend_q && !push_fl);
  assign cnt_m1    = count_q - CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !fast) begin
          if (plan_i.rep) state_d = S_REP_FL;
          else if (!plan_i.pt_v) state_d = S_END_FL;
          else if (in_rtl && (count_q != FULL)) state_d = S_PT_ACT;
          else state_d = S_PT_FL;
        end
      end
      S_REP_FL: begin
        if (fl_done) state_d = S_REP_EM;
      end
      S_REP_EM: begin
        if (out_can) state_d = plan_q.pt_v ? S_PT_ACT : S_IDLE;
      end
      S_PT_FL: begin
        if (fl_done) state_d = S_PT_ACT;
      end
      S_PT_ACT: begin
        if (rtl_q) state_d = plan_q.str_end ? S_END_FL : S_IDLE;
        else if (out_can) state_d = S_IDLE;
      end
      S_END_FL: begin
        if (fl_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory accesses, fill count and output loads
  always_comb begin
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_wdata = plan_i.pt;
    ram_re    = issue;
    load      = push_fl;
    ld_cp     = ram_rdata;
    ld_last   = 1'b1;

    if (issue) count_d = cnt_m1;

    case (state_q)
      S_IDLE: begin
        if (accept && fast_wr) begin
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
        end
        if (accept && fast_em) begin
          load  = 1'b1;
          ld_cp = plan_i.pt;
        end
      end
      S_REP_FL: ld_last = 1'b0;
      S_REP_EM: begin
        load    = out_can;
        ld_cp   = CP_REPL;
        ld_last = !plan_q.pt_v;
      end
      S_PT_FL: ld_last = (count_q == '0) && rtl_q && !plan_q.str_end;
      S_PT_ACT: begin
        if (rtl_q) begin
          ram_we    = 1'b1;
          ram_wdata = plan_q.pt;
          count_d   = count_q + CW'(1);
        end else begin
          load  = out_can;
          ld_cp = plan_q.pt;
        end
      end
      S_END_FL: ld_last = (count_q == '0);
      default: ld_last = 1'b1;
    endcase
  end

  assign ov_d = load || (ov_q && !out_ready_i);

  u8rr_ram #(
    .WIDTH (CP_W),
    .DEPTH (RUN_DEPTH)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_m1[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  // plan and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      plan_q <= plan_i;
      rtl_q  <= in_rtl;
    end
    if (load) begin
      ocp_q   <= ld_cp;
      olast_q <= ld_last;
    end
  end

  assign out_valid_o     = ov_q;
  assign code_point_o    = ocp_q;
  assign last_of_burst_o = olast_q;

`ifndef SYNTHESIS
  // fill count stays within the run memory
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL) else $error("run count beyond depth");

  // no write while a read is issued
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re)) else $error("run memory write and read together");

  // a read in flight only while draining
  a_pend_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> flush_act) else $error("read pending outside drain");

  // output register loaded only when it has room
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_can) else $error("output register overwritten");

  // a drained entry waits in the read register until it is pushed
  a_read_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> pend_q) else $error("read data lost");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for utf8_decode_rtl_reorder_core
// Feeds utf-8 strings byte by byte, predicts the code points in display order
// with a cycle-free model of the decoder and its right-to-left run buffer,
// and checks every result request against the oldest expected point.
// ----------------------------------------------------------------------------

module tb;
  import u8rr_pkg::*;

  localparam int unsigned RUN_DEPTH   = 32;
  localparam int          STALL_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 40;
  localparam int          RTOL_N      = 36;

  // right-to-left spans, inclusive
  localparam cp_t RTOL_FIRST [RTOL_N] = '{
    21'h005BE, 21'h005C0, 21'h005C3, 21'h005C6, 21'h005D0, 21'h00608,
    21'h0060B, 21'h0060D, 21'h0061B, 21'h0066D, 21'h00671, 21'h006E5,
    21'h006EE, 21'h006FA, 21'h00712, 21'h0074D, 21'h007B1, 21'h007F4,
    21'h007FA, 21'h0081A, 21'h00824, 21'h00828, 21'h00830, 21'h0085E,
    21'h0200F, 21'h0FB1D, 21'h0FB1F, 21'h0FB2A, 21'h0FD50, 21'h0FE70,
    21'h10800, 21'h10920, 21'h10A10, 21'h10A40, 21'h10B40, 21'h1EE00
  };
  localparam cp_t RTOL_LAST [RTOL_N] = '{
    21'h005BE, 21'h005C0, 21'h005C3, 21'h005C6, 21'h005F4, 21'h00608,
    21'h0060B, 21'h0060D, 21'h0064A, 21'h0066F, 21'h006D5, 21'h006E6,
    21'h006EF, 21'h00710, 21'h0072F, 21'h007A5, 21'h007EA, 21'h007F5,
    21'h00815, 21'h0081A, 21'h00824, 21'h00828, 21'h00858, 21'h008AC,
    21'h0200F, 21'h0FB1D, 21'h0FB28, 21'h0FD3D, 21'h0FDFC, 21'h0FEFC,
    21'h1091B, 21'h10A00, 21'h10A33, 21'h10B35, 21'h10C48, 21'h1EEBB
  };

  typedef struct packed {
    cp_t  cp;
    logic last;
  } shown_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic gaps_on = 1'b1;
  int   err_cnt = 0;
  int   bytes_sent = 0;

  u8rr_in_if  in_if ();
  u8rr_out_if out_if ();

  utf8_decode_rtl_reorder_core #(
    .RUN_DEPTH(RUN_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // display-order prediction
  // ---------------------------------------------------------------------------
  shown_pt_t exp_points [$];
  cp_t       burst_pts [$];

  byte_t      lead_q;
  logic [1:0] cont_cnt;
  cp_t        acc_val;
  logic       skip_cont;
  logic       run_on;
  cp_t        run_buf [RUN_DEPTH];
  int         run_len;

  function automatic logic rtol_point(cp_t c);
    for (int k = 0; k < RTOL_N; k++) begin
      if (c >= RTOL_FIRST[k] && c <= RTOL_LAST[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic space_or_punct(cp_t c);
    return (c >= 21'h09 && c <= 21'h0D) || (c >= 21'h20 && c <= 21'h2F) ||
           (c >= 21'h3A && c <= 21'h40) || (c >= 21'h5B && c <= 21'h60) ||
           (c >= 21'h7B && c <= 21'h7E);
  endfunction

  function automatic void clear_seq();
    lead_q   = '0;
    cont_cnt = '0;
    acc_val  = '0;
  endfunction

  // buffered run leaves newest first
  function automatic void drain_run();
    while (run_len > 0) begin
      run_len--;
      burst_pts.insert(burst_pts.size(), run_buf[run_len]);
    end
  endfunction

  function automatic void route_point(cp_t c, logic e);
    logic rtol;
    rtol = rtol_point(c) || (run_on && space_or_punct(c));
    if (rtol) begin
      if (!run_on) begin
        run_on  = 1'b1;
        run_len = 0;
      end
      if (run_len >= RUN_DEPTH) drain_run();
      run_buf[run_len] = c;
      run_len++;
      if (e) begin
        drain_run();
        run_on = 1'b0;
      end
    end else begin
      if (run_on) begin
        drain_run();
        run_on = 1'b0;
      end
      burst_pts.insert(burst_pts.size(), c);
    end
  endfunction

  function automatic void open_seq(byte_t b, logic e);
    if (b <= ASCII_MAX) begin
      route_point(cp_t'(b), e);
    end else if (b <= LEAD4_MAX) begin
      if (e) begin
        route_point(CP_REPL, e);
      end else begin
        lead_q   = b;
        cont_cnt = '0;
        acc_val  = (b <= LEAD2_MAX) ? cp_t'(b[4:0]) : cp_t'(b[3:0]);
      end
    end else begin
      route_point(CP_REPL, e);
      skip_cont = !e;
    end
  endfunction

  function automatic void decode_byte(byte_t b, logic e);
    logic is_cont;
    int   need;
    cp_t  v;
    is_cont = (b[7:6] == CONT_TAG);
    burst_pts.delete();
    if (!(skip_cont && is_cont)) begin
      if (lead_q != '0) begin
        if (is_cont) begin
          need     = (lead_q <= LEAD2_MAX) ? 1 : ((lead_q <= LEAD3_MAX) ? 2 : 3);
          acc_val  = {acc_val[CP_W-7:0], b[5:0]};
          cont_cnt = cont_cnt + 2'd1;
          if (int'(cont_cnt) >= need) begin
            v = (acc_val > CP_MAX) ? CP_REPL : acc_val;
            clear_seq();
            route_point(v, e);
          end else if (e) begin
            route_point(CP_REPL, e);
          end
        end else begin
          // broken sequence, the byte starts afresh
          clear_seq();
          route_point(CP_REPL, 1'b0);
          open_seq(b, e);
        end
      end else begin
        skip_cont = 1'b0;
        open_seq(b, e);
      end
    end
    if (e) begin
      drain_run();
      clear_seq();
      skip_cont = 1'b0;
      run_on    = 1'b0;
      run_len   = 0;
    end
    foreach (burst_pts[k]) begin
      exp_points.insert(exp_points.size(),
                        shown_pt_t'{cp: burst_pts[k],
                                    last: (k == burst_pts.size() - 1)});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result check and prediction, both on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    shown_pt_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (exp_points.size() == 0) begin
        err_cnt++;
        if (err_cnt < 50) $error("unexpected code point %h", out_if.code_point);
      end else begin
        want = exp_points.pop_front();
        if (out_if.code_point !== want.cp) begin
          err_cnt++;
          if (err_cnt < 50)
            $error("code_point: expected %h, got %h", want.cp, out_if.code_point);
        end
        if (out_if.last_of_burst !== want.last) begin
          err_cnt++;
          if (err_cnt < 50)
            $error("last_of_burst: expected %b, got %b", want.last, out_if.last_of_burst);
        end
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) decode_byte(in_if.data_byte, in_if.string_end);
  end

  // watchdog on cycles with no request moving either way
  initial begin : watchdog
    int idle_cyc;
    idle_cyc = 0;
    while (idle_cyc < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cyc = 0;
      else idle_cyc++;
    end
    $display("utf8_decode_rtl_reorder_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side stalls
  initial begin : result_stall
    int stall;
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // byte requests and string building
  // ---------------------------------------------------------------------------
  byte_t str_bytes [$];

  task automatic send_byte(byte_t b, logic e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.string_end <= e;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string();
    foreach (str_bytes[k]) send_byte(str_bytes[k], k == str_bytes.size() - 1);
    str_bytes.delete();
  endtask

  task automatic send_list(byte_t seq [$], logic e_last);
    foreach (seq[k]) send_byte(seq[k], e_last && (k == seq.size() - 1));
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (exp_points.size() != 0);
  endtask

  function automatic void put_utf8(cp_t c);
    if (c < 21'h80) begin
      str_bytes.insert(str_bytes.size(), c[7:0]);
    end else if (c < 21'h800) begin
      str_bytes.insert(str_bytes.size(), {3'b110, c[10:6]});
      str_bytes.insert(str_bytes.size(), {2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      str_bytes.insert(str_bytes.size(), {4'b1110, c[15:12]});
      str_bytes.insert(str_bytes.size(), {2'b10, c[11:6]});
      str_bytes.insert(str_bytes.size(), {2'b10, c[5:0]});
    end else begin
      str_bytes.insert(str_bytes.size(), {5'b11110, c[20:18]});
      str_bytes.insert(str_bytes.size(), {2'b10, c[17:12]});
      str_bytes.insert(str_bytes.size(), {2'b10, c[11:6]});
      str_bytes.insert(str_bytes.size(), {2'b10, c[5:0]});
    end
  endfunction

  // right-to-left point, or one just outside a span when edges is set
  function automatic cp_t pick_rtol(logic edges);
    int k;
    k = $urandom_range(0, RTOL_N - 1);
    if (edges) begin
      case ($urandom_range(0, 4))
        0: return RTOL_FIRST[k];
        1: return RTOL_LAST[k];
        2: return RTOL_FIRST[k] - 21'd1;
        3: return RTOL_LAST[k] + 21'd1;
        default: ;
      endcase
    end
    return cp_t'($urandom_range(RTOL_FIRST[k], RTOL_LAST[k]));
  endfunction

  function automatic cp_t pick_punct();
    case ($urandom_range(0, 5))
      0: return cp_t'($urandom_range('h09, 'h0D));
      1: return cp_t'($urandom_range('h20, 'h2F));
      2: return cp_t'($urandom_range('h3A, 'h40));
      3: return cp_t'($urandom_range('h5B, 'h60));
      4: return cp_t'($urandom_range('h7B, 'h7E));
      default: return 21'h20;
    endcase
  endfunction

  function automatic void add_segment();
    int kind;
    int start_n;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      put_utf8(cp_t'($urandom_range(0, 'h7F)));
    end else if (kind < 35) begin
      put_utf8(pick_punct());
    end else if (kind < 60) begin
      put_utf8(pick_rtol(1'b1));
    end else if (kind < 72) begin
      case ($urandom_range(0, 9))
        0: put_utf8(21'h80);
        1: put_utf8(21'h7FF);
        2: put_utf8(21'h800);
        3: put_utf8(21'hFFFF);
        4: put_utf8(21'h10000);
        5: put_utf8(CP_MAX);
        default: put_utf8(cp_t'($urandom_range('h80, 'h10FFFF)));
      endcase
    end else if (kind < 78) begin
      // four-byte form above the code space
      put_utf8(cp_t'($urandom_range('h110000, 'h1FFFFF)));
    end else if (kind < 85) begin
      // truncated multi-byte form
      start_n = str_bytes.size();
      put_utf8(cp_t'($urandom_range('h80, 'h1FFFFF)));
      repeat ($urandom_range(1, str_bytes.size() - start_n - 1)) void'(str_bytes.pop_back());
    end else if (kind < 90) begin
      str_bytes.insert(str_bytes.size(), byte_t'($urandom_range('hF8, 'hFF)));
      repeat ($urandom_range(0, 3))
        str_bytes.insert(str_bytes.size(), byte_t'($urandom_range('h80, 'hBF)));
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 3))
        str_bytes.insert(str_bytes.size(), byte_t'($urandom_range('h80, 'hBF)));
    end else begin
      str_bytes.insert(str_bytes.size(), byte_t'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ascii extremes, a run with a space inside, flush by ascii and by string end
  task automatic test_ascii_and_rtl_run();
    send_list('{8'h00, 8'hD7, 8'h90, 8'h20, 8'hD7, 8'h91, 8'h7F, 8'hD7, 8'h90}, 1'b1);
  endtask

  // bad lead with swallowed continuations, stray lead, broken and pending forms
  task automatic test_broken_sequences();
    send_list('{8'hFF, 8'h80, 8'hBF, 8'h41, 8'h80, 8'h80, 8'hE0, 8'h41, 8'hE0, 8'h80},
              1'b1);
  endtask

  // value above the code space, four-byte rtl point, bad lead on the last byte
  task automatic test_four_byte_forms();
    send_list('{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF0, 8'h9E, 8'hBA, 8'hBB, 8'hF8}, 1'b1);
  endtask

  // runs longer than the buffer, mostly punctuation to keep them short
  task automatic test_run_overflow();
    repeat (2) begin
      put_utf8(pick_rtol(1'b0));
      repeat ($urandom_range(RUN_DEPTH + 1, RUN_DEPTH + 8)) begin
        if ($urandom_range(0, 3) != 0) put_utf8(pick_punct());
        else put_utf8(pick_rtol(1'b0));
      end
      send_string();
    end
  endtask

  task automatic test_random_strings();
    int goal;
    int half;
    goal = bytes_sent + 170;
    half = bytes_sent + 85;
    while (bytes_sent < goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 10)) add_segment();
      send_string();
      if (half > 0 && bytes_sent >= half) begin
        hold_until_drained();
        half = 0;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.string_end = 1'b0;
    lead_q           = '0;
    cont_cnt         = '0;
    acc_val          = '0;
    skip_cont        = 1'b0;
    run_on           = 1'b0;
    run_len          = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_ascii_and_rtl_run();
    test_broken_sequences();
    test_four_byte_forms();
    test_run_overflow();
    test_random_strings();

    in_if.valid <= 1'b0;
    while (exp_points.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (err_cnt == 0) $display("utf8_decode_rtl_reorder_core: match");
    else $display("utf8_decode_rtl_reorder_core: mismatch");
    $finish;
  end

endmodule
